// ----- design/climate_threshold_relay_controller_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the relay controller core.
// ----------------------------------------------------------------------------
`ifndef CLIMATE_THRESHOLD_RELAY_CONTROLLER_UNIT_ASSERT_SVH
`define CLIMATE_THRESHOLD_RELAY_CONTROLLER_UNIT_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define CTRC_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define CTRC_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ----- design/ctrc_pkg.sv -----
// ----------------------------------------------------------------------------
// Relay controller package
// Word types, limits and command codes shared by the controller modules.
// ----------------------------------------------------------------------------
package ctrc_pkg;

  localparam logic [6:0] LIMIT_MAX      = 7'd99;
  localparam logic [6:0] T_HI_RESET     = 7'd31;
  localparam logic [6:0] T_LO_RESET     = 7'd29;
  localparam logic [6:0] H_HI_RESET     = 7'd99;
  localparam logic [6:0] H_LO_RESET     = 7'd0;

  localparam logic [7:0] CMD_T_HI_UP    = 8'h31;
  localparam logic [7:0] CMD_T_HI_DOWN  = 8'h32;
  localparam logic [7:0] CMD_H_HI_UP    = 8'h33;
  localparam logic [7:0] CMD_H_HI_DOWN  = 8'h34;
  localparam logic [7:0] CMD_VIEW       = 8'h35;
  localparam logic [7:0] CMD_CUR_PREV   = 8'h36;
  localparam logic [7:0] CMD_CUR_NEXT   = 8'h37;
  localparam logic [7:0] CMD_HIST_CLEAR = 8'h39;
  localparam logic [7:0] CMD_T_LO_UP    = 8'h61;
  localparam logic [7:0] CMD_T_LO_DOWN  = 8'h62;
  localparam logic [7:0] CMD_H_LO_UP    = 8'h63;
  localparam logic [7:0] CMD_H_LO_DOWN  = 8'h64;
  localparam logic [7:0] CMD_BEEP       = 8'h65;

  typedef struct packed {
    logic       action;
    logic [7:0] command;
    logic [7:0] temp_int;
    logic [7:0] temp_frac;
    logic [7:0] humi_int;
    logic [7:0] humi_frac;
  } ctrc_item_t;

  typedef struct packed {
    logic       heater_on;
    logic       cooler_on;
    logic       beep_on;
    logic       save_strobe;
    logic [5:0] save_slot;
    logic [5:0] record_count;
    logic [6:0] temp_high_limit;
    logic [6:0] temp_low_limit;
    logic [6:0] humi_high_limit;
    logic [6:0] humi_low_limit;
    logic       history_view;
    logic [5:0] history_cursor;
  } ctrc_result_t;

endpackage

// ----- design/ctrc_in_if.sv -----
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one sample or command word.
// ----------------------------------------------------------------------------
interface ctrc_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] command;
  logic [7:0] temp_int;
  logic [7:0] temp_frac;
  logic [7:0] humi_int;
  logic [7:0] humi_frac;

  modport source (
    output valid, action, command, temp_int, temp_frac, humi_int, humi_frac,
    input  ready
  );
  modport sink (
    input  valid, action, command, temp_int, temp_frac, humi_int, humi_frac,
    output ready
  );
endinterface

// ----- design/ctrc_out_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one controller status word.
// ----------------------------------------------------------------------------
interface ctrc_out_if;
  logic       valid;
  logic       ready;
  logic       heater_on;
  logic       cooler_on;
  logic       beep_on;
  logic       save_strobe;
  logic [5:0] save_slot;
  logic [5:0] record_count;
  logic [6:0] temp_high_limit;
  logic [6:0] temp_low_limit;
  logic [6:0] humi_high_limit;
  logic [6:0] humi_low_limit;
  logic       history_view;
  logic [5:0] history_cursor;

  modport source (
    output valid, heater_on, cooler_on, beep_on, save_strobe, save_slot,
           record_count, temp_high_limit, temp_low_limit, humi_high_limit,
           humi_low_limit, history_view, history_cursor,
    input  ready
  );
  modport sink (
    input  valid, heater_on, cooler_on, beep_on, save_strobe, save_slot,
           record_count, temp_high_limit, temp_low_limit, humi_high_limit,
           humi_low_limit, history_view, history_cursor,
    output ready
  );
endinterface

// ----- design/climate_threshold_relay_controller_unit.sv -----
// ----------------------------------------------------------------------------
// Climate threshold relay controller
// Takes sensor samples and command words and returns relay, beeper, save and
// threshold and history status, one result word for each input word.
// ----------------------------------------------------------------------------
// The controller accepts one word every clock cycle while the result channel
// is ready. Each word passes through the input register and then the result
// register, with the threshold, history and relay state updated by a single
// pass of compare and step logic between the two. A stall on the result
// channel holds the pipeline without losing words. No initialization pass
// is needed after reset.
module climate_threshold_relay_controller_unit
  import ctrc_pkg::*;
#(
  parameter int HISTORY_SLOTS = 50,
  parameter int SAVE_PERIOD   = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  ctrc_in_if.sink    in_chan,
  ctrc_out_if.source out_chan
);

  logic         item_valid;
  ctrc_item_t   item;
  ctrc_result_t result;
  logic         space;
  logic         advance;

  assign advance = item_valid && space;

  ctrc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ctrc_core #(
    .HISTORY_SLOTS (HISTORY_SLOTS),
    .SAVE_PERIOD   (SAVE_PERIOD)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .result  (result)
  );

  ctrc_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance),
    .result   (result),
    .space    (space),
    .out_chan (out_chan)
  );

endmodule

// ----- design/ctrc_in_stage.sv -----
// ----------------------------------------------------------------------------
// Input stage
// Registers the incoming word and hands it to the core.
// ----------------------------------------------------------------------------
module ctrc_in_stage
  import ctrc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  ctrc_in_if.sink      in_chan,
  input  logic         advance,
  output logic         item_valid,
  output ctrc_item_t   item
);

  logic       valid_r;
  logic       valid_nxt;
  ctrc_item_t item_r;
  logic       load;

  assign in_chan.ready = !valid_r || advance;
  assign load          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.action    <= in_chan.action;
      item_r.command   <= in_chan.command;
      item_r.temp_int  <= in_chan.temp_int;
      item_r.temp_frac <= in_chan.temp_frac;
      item_r.humi_int  <= in_chan.humi_int;
      item_r.humi_frac <= in_chan.humi_frac;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- design/ctrc_core.sv -----
// ----------------------------------------------------------------------------
// Controller core
// Holds thresholds, history and relay state; evaluates one word per cycle while the pipeline advances.
// ----------------------------------------------------------------------------
`include "climate_threshold_relay_controller_unit_assert.svh"

module ctrc_core
  import ctrc_pkg::*;
#(
  parameter int HISTORY_SLOTS = 50,
  parameter int SAVE_PERIOD   = 10
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         advance,
  input  ctrc_item_t   item,
  output ctrc_result_t result
);

  localparam logic [6:0] SLOTS  = 7'(HISTORY_SLOTS);
  localparam logic [3:0] PERIOD = 4'(SAVE_PERIOD);

  logic [6:0] t_hi_r, t_hi_nxt, t_lo_r, t_lo_nxt;
  logic [6:0] h_hi_r, h_hi_nxt, h_lo_r, h_lo_nxt;
  logic       view_r, view_nxt;
  logic [5:0] cursor_r, cursor_nxt;
  logic [5:0] records_r, records_nxt;
  logic       beep_en_r, beep_en_nxt;
  logic [3:0] count_r, count_nxt;
  logic       heater_r, heater_nxt, cooler_r, cooler_nxt, beeper_r, beeper_nxt;

  logic [11:0] t10, h10;
  logic        cold, hot, humi_bad;
  logic [6:0]  records_inc;
  logic [5:0]  records_last;
  logic        strobe;
  logic [5:0]  slot;

  always_comb begin
    t_hi_nxt    = t_hi_r;
    t_lo_nxt    = t_lo_r;
    h_hi_nxt    = h_hi_r;
    h_lo_nxt    = h_lo_r;
    view_nxt    = view_r;
    cursor_nxt  = cursor_r;
    records_nxt = records_r;
    beep_en_nxt = beep_en_r;
    count_nxt   = count_r;
    heater_nxt  = heater_r;
    cooler_nxt  = cooler_r;
    beeper_nxt  = beeper_r;
    strobe      = 1'b0;
    slot        = 6'd0;

    t10 = 12'(item.temp_int) * 12'd10 + 12'(item.temp_frac);
    h10 = 12'(item.humi_int) * 12'd10 + 12'(item.humi_frac);
    cold     = t10 < 12'(t_lo_r) * 12'd10;
    hot      = t10 > 12'(t_hi_r) * 12'd10;
    humi_bad = (h10 > 12'(h_hi_r) * 12'd10) || (h10 < 12'(h_lo_r) * 12'd10);
    records_inc  = 7'(records_r) + 7'd1;
    records_last = (records_r != 6'd0) ? records_r - 6'd1 : 6'd0;

    if (item.action) begin
      unique case (item.command)
        CMD_T_HI_UP: begin
          t_hi_nxt = (t_hi_r >= LIMIT_MAX) ? LIMIT_MAX : t_hi_r + 7'd1;
        end
        CMD_T_HI_DOWN: begin
          if (t_hi_r > t_lo_r) t_hi_nxt = t_hi_r - 7'd1;
        end
        CMD_H_HI_UP: begin
          h_hi_nxt = (h_hi_r >= LIMIT_MAX) ? LIMIT_MAX : h_hi_r + 7'd1;
        end
        CMD_H_HI_DOWN: begin
          if (h_hi_r > h_lo_r) h_hi_nxt = h_hi_r - 7'd1;
        end
        CMD_VIEW: begin
          view_nxt = !view_r;
        end
        CMD_CUR_PREV: begin
          if (view_r) begin
            cursor_nxt = (cursor_r != 6'd0) ? cursor_r - 6'd1 : records_last;
          end
        end
        CMD_CUR_NEXT: begin
          if (view_r) begin
            if (records_r != 6'd0 && cursor_r < records_last) begin
              cursor_nxt = cursor_r + 6'd1;
            end else begin
              cursor_nxt = 6'd0;
            end
          end
        end
        CMD_HIST_CLEAR: begin
          records_nxt = 6'd0;
        end
        CMD_T_LO_UP: begin
          if (t_hi_r > t_lo_r) t_lo_nxt = t_lo_r + 7'd1;
        end
        CMD_T_LO_DOWN: begin
          if (t_lo_r != 7'd0) t_lo_nxt = t_lo_r - 7'd1;
        end
        CMD_H_LO_UP: begin
          if (h_hi_r > h_lo_r) h_lo_nxt = h_lo_r + 7'd1;
        end
        CMD_H_LO_DOWN: begin
          if (h_lo_r != 7'd0) h_lo_nxt = h_lo_r - 7'd1;
        end
        CMD_BEEP: begin
          beep_en_nxt = !beep_en_r;
          if (beep_en_r) beeper_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end else begin
      if (cold || hot || humi_bad) begin
        beeper_nxt = beep_en_r;
        if (cold) begin
          heater_nxt = 1'b1;
          cooler_nxt = 1'b0;
        end else if (hot) begin
          heater_nxt = 1'b0;
          cooler_nxt = 1'b1;
        end
      end else begin
        heater_nxt = 1'b0;
        cooler_nxt = 1'b0;
        beeper_nxt = 1'b0;
      end

      if (count_r >= PERIOD) begin
        strobe      = 1'b1;
        slot        = records_r;
        records_nxt = (records_inc >= SLOTS) ? 6'd0 : records_inc[5:0];
        count_nxt   = 4'd0;
      end else begin
        count_nxt = count_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_hi_r    <= T_HI_RESET;
      t_lo_r    <= T_LO_RESET;
      h_hi_r    <= H_HI_RESET;
      h_lo_r    <= H_LO_RESET;
      view_r    <= 1'b0;
      cursor_r  <= 6'd0;
      records_r <= 6'd0;
      beep_en_r <= 1'b0;
      count_r   <= 4'd0;
      heater_r  <= 1'b0;
      cooler_r  <= 1'b0;
      beeper_r  <= 1'b0;
    end else if (advance) begin
      t_hi_r    <= t_hi_nxt;
      t_lo_r    <= t_lo_nxt;
      h_hi_r    <= h_hi_nxt;
      h_lo_r    <= h_lo_nxt;
      view_r    <= view_nxt;
      cursor_r  <= cursor_nxt;
      records_r <= records_nxt;
      beep_en_r <= beep_en_nxt;
      count_r   <= count_nxt;
      heater_r  <= heater_nxt;
      cooler_r  <= cooler_nxt;
      beeper_r  <= beeper_nxt;
    end
  end

  always_comb begin
    result.heater_on       = heater_nxt;
    result.cooler_on       = cooler_nxt;
    result.beep_on         = beeper_nxt;
    result.save_strobe     = strobe;
    result.save_slot       = slot;
    result.record_count    = records_nxt;
    result.temp_high_limit = t_hi_nxt;
    result.temp_low_limit  = t_lo_nxt;
    result.humi_high_limit = h_hi_nxt;
    result.humi_low_limit  = h_lo_nxt;
    result.history_view    = view_nxt;
    result.history_cursor  = cursor_nxt;
  end

  `CTRC_ASSERT_ALWAYS(a_temp_order, t_lo_r <= t_hi_r && t_hi_r <= LIMIT_MAX, "temperature limits out of order")
  `CTRC_ASSERT_ALWAYS(a_humi_order, h_lo_r <= h_hi_r && h_hi_r <= LIMIT_MAX, "humidity limits out of order")
  `CTRC_ASSERT_ALWAYS(a_records_range, 7'(records_r) < SLOTS, "record count past slot count")
  `CTRC_ASSERT_ALWAYS(a_relay_excl, !(heater_r && cooler_r), "heater and cooler both on")
  `CTRC_ASSERT_NEXT(a_state_hold, !advance, $stable(records_r) && $stable(count_r), "state moved without a word")

endmodule

// ----- design/ctrc_out_stage.sv -----
// ----------------------------------------------------------------------------
// Output stage
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module ctrc_out_stage
  import ctrc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  ctrc_result_t result,
  output logic         space,
  ctrc_out_if.source   out_chan
);

  logic         valid_r;
  logic         valid_nxt;
  ctrc_result_t result_r;

  assign space = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_chan.valid           = valid_r;
  assign out_chan.heater_on       = result_r.heater_on;
  assign out_chan.cooler_on       = result_r.cooler_on;
  assign out_chan.beep_on         = result_r.beep_on;
  assign out_chan.save_strobe     = result_r.save_strobe;
  assign out_chan.save_slot       = result_r.save_slot;
  assign out_chan.record_count    = result_r.record_count;
  assign out_chan.temp_high_limit = result_r.temp_high_limit;
  assign out_chan.temp_low_limit  = result_r.temp_low_limit;
  assign out_chan.humi_high_limit = result_r.humi_high_limit;
  assign out_chan.humi_low_limit  = result_r.humi_low_limit;
  assign out_chan.history_view    = result_r.history_view;
  assign out_chan.history_cursor  = result_r.history_cursor;

endmodule

// ----- tb/ctrc_status_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Relay controller status checker
// Watches both channels of the controller. Every accepted input word updates
// a local copy of the thresholds, history and relay state, and queues the
// status word that the controller must return for it. Every accepted result
// word is compared field by field with the oldest queued status word.
// ----------------------------------------------------------------------------
module ctrc_status_checker
  import ctrc_pkg::*;
#(
  parameter int HISTORY_SLOTS = 50,
  parameter int SAVE_PERIOD   = 10
) (
  input  logic clk,
  input  logic rst_n,
  ctrc_in_if   in_mon,
  ctrc_out_if  out_mon,
  output int   fail_count,
  output int   pending_count
);

  logic [6:0]   t_hi_lim, t_lo_lim, h_hi_lim, h_lo_lim;
  logic         view_on, beep_en, heater, cooler, beeper;
  logic [5:0]   cursor, records;
  logic [3:0]   sample_cnt;
  ctrc_result_t status_due[$];

  function automatic logic [6:0] step_up(input logic [6:0] v);
    return (v >= LIMIT_MAX) ? LIMIT_MAX : v + 7'd1;
  endfunction

  function automatic ctrc_result_t next_status(input ctrc_item_t w);
    ctrc_result_t r;
    int unsigned  t10, h10;
    logic         cold, hot, humi_bad;
    r = '0;
    if (w.action) begin
      case (w.command)
        CMD_T_HI_UP:    t_hi_lim = step_up(t_hi_lim);
        CMD_T_HI_DOWN:  if (t_hi_lim > t_lo_lim) t_hi_lim = t_hi_lim - 7'd1;
        CMD_H_HI_UP:    h_hi_lim = step_up(h_hi_lim);
        CMD_H_HI_DOWN:  if (h_hi_lim > h_lo_lim) h_hi_lim = h_hi_lim - 7'd1;
        CMD_VIEW:       view_on = ~view_on;
        CMD_CUR_PREV: begin
          if (view_on) begin
            if (cursor > 0) cursor = cursor - 6'd1;
            else cursor = (records > 0) ? records - 6'd1 : 6'd0;
          end
        end
        CMD_CUR_NEXT: begin
          if (view_on) begin
            if (records > 0 && cursor < records - 6'd1) cursor = cursor + 6'd1;
            else cursor = 6'd0;
          end
        end
        CMD_HIST_CLEAR: records = 6'd0;
        CMD_T_LO_UP:    if (t_hi_lim > t_lo_lim) t_lo_lim = t_lo_lim + 7'd1;
        CMD_T_LO_DOWN:  if (t_lo_lim > 0) t_lo_lim = t_lo_lim - 7'd1;
        CMD_H_LO_UP:    if (h_hi_lim > h_lo_lim) h_lo_lim = h_lo_lim + 7'd1;
        CMD_H_LO_DOWN:  if (h_lo_lim > 0) h_lo_lim = h_lo_lim - 7'd1;
        CMD_BEEP: begin
          beep_en = ~beep_en;
          if (!beep_en) beeper = 1'b0;
        end
        default: ;
      endcase
    end else begin
      t10 = int'(w.temp_int) * 10 + int'(w.temp_frac);
      h10 = int'(w.humi_int) * 10 + int'(w.humi_frac);
      cold = t10 < int'(t_lo_lim) * 10;
      hot = t10 > int'(t_hi_lim) * 10;
      humi_bad = (h10 > int'(h_hi_lim) * 10) || (h10 < int'(h_lo_lim) * 10);
      if (cold || hot || humi_bad) begin
        beeper = beep_en;
        if (cold) begin
          heater = 1'b1;
          cooler = 1'b0;
        end else if (hot) begin
          heater = 1'b0;
          cooler = 1'b1;
        end
      end else begin
        heater = 1'b0;
        cooler = 1'b0;
        beeper = 1'b0;
      end
      if (sample_cnt >= SAVE_PERIOD) begin
        r.save_strobe = 1'b1;
        r.save_slot = records;
        records = (int'(records) + 1 >= HISTORY_SLOTS) ? 6'd0 : records + 6'd1;
        sample_cnt = 4'd0;
      end else begin
        sample_cnt = sample_cnt + 4'd1;
      end
    end
    r.heater_on = heater;
    r.cooler_on = cooler;
    r.beep_on = beeper;
    r.record_count = records;
    r.temp_high_limit = t_hi_lim;
    r.temp_low_limit = t_lo_lim;
    r.humi_high_limit = h_hi_lim;
    r.humi_low_limit = h_lo_lim;
    r.history_view = view_on;
    r.history_cursor = cursor;
    return r;
  endfunction

  task automatic log_failure(input string why, input ctrc_result_t exp,
                             input ctrc_result_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("ERROR at %0t: %s\n  expected %p\n  actual   %p", $time, why, exp, got);
  endtask

  always @(posedge clk) begin : watch
    ctrc_item_t   w;
    ctrc_result_t got, exp;
    string        bad;
    if (!rst_n) begin
      t_hi_lim = T_HI_RESET;
      t_lo_lim = T_LO_RESET;
      h_hi_lim = H_HI_RESET;
      h_lo_lim = H_LO_RESET;
      view_on = 1'b0;
      beep_en = 1'b0;
      heater = 1'b0;
      cooler = 1'b0;
      beeper = 1'b0;
      cursor = 6'd0;
      records = 6'd0;
      sample_cnt = 4'd0;
      status_due.delete();
      fail_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        w.action = in_mon.action;
        w.command = in_mon.command;
        w.temp_int = in_mon.temp_int;
        w.temp_frac = in_mon.temp_frac;
        w.humi_int = in_mon.humi_int;
        w.humi_frac = in_mon.humi_frac;
        status_due.push_back(next_status(w));
      end
      if (out_mon.valid && out_mon.ready) begin
        got.heater_on = out_mon.heater_on;
        got.cooler_on = out_mon.cooler_on;
        got.beep_on = out_mon.beep_on;
        got.save_strobe = out_mon.save_strobe;
        got.save_slot = out_mon.save_slot;
        got.record_count = out_mon.record_count;
        got.temp_high_limit = out_mon.temp_high_limit;
        got.temp_low_limit = out_mon.temp_low_limit;
        got.humi_high_limit = out_mon.humi_high_limit;
        got.humi_low_limit = out_mon.humi_low_limit;
        got.history_view = out_mon.history_view;
        got.history_cursor = out_mon.history_cursor;
        if (status_due.size() == 0) begin
          log_failure("result word with no input word pending", '0, got);
        end else begin
          exp = status_due.pop_front();
          bad = "";
          if (got.heater_on !== exp.heater_on) bad = {bad, " heater_on"};
          if (got.cooler_on !== exp.cooler_on) bad = {bad, " cooler_on"};
          if (got.beep_on !== exp.beep_on) bad = {bad, " beep_on"};
          if (got.save_strobe !== exp.save_strobe) bad = {bad, " save_strobe"};
          if (got.save_slot !== exp.save_slot) bad = {bad, " save_slot"};
          if (got.record_count !== exp.record_count) bad = {bad, " record_count"};
          if (got.temp_high_limit !== exp.temp_high_limit) bad = {bad, " temp_high_limit"};
          if (got.temp_low_limit !== exp.temp_low_limit) bad = {bad, " temp_low_limit"};
          if (got.humi_high_limit !== exp.humi_high_limit) bad = {bad, " humi_high_limit"};
          if (got.humi_low_limit !== exp.humi_low_limit) bad = {bad, " humi_low_limit"};
          if (got.history_view !== exp.history_view) bad = {bad, " history_view"};
          if (got.history_cursor !== exp.history_cursor) bad = {bad, " history_cursor"};
          if (bad != "") log_failure({"mismatch in", bad}, exp, got);
        end
      end
    end
    pending_count = status_due.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Relay controller testbench
// Drives the controller with directed samples and commands, then random
// bursts of samples, threshold steps, history navigation and noise words,
// history clears and beeper toggles, random idling on both channels and one
// long result stall. The checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;
  import ctrc_pkg::*;

  localparam int HISTORY_SLOTS   = 50;
  localparam int SAVE_PERIOD     = 10;
  localparam int RANDOM_WORDS    = 800;
  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int IDLE_PERCENT    = 11;

  localparam logic [7:0] STEP_CMDS [8] = '{CMD_T_HI_UP, CMD_T_HI_DOWN, CMD_H_HI_UP,
                                           CMD_H_HI_DOWN, CMD_T_LO_UP, CMD_T_LO_DOWN,
                                           CMD_H_LO_UP, CMD_H_LO_DOWN};
  localparam logic [7:0] NAV_CMDS [4] = '{CMD_VIEW, CMD_CUR_PREV, CMD_CUR_NEXT,
                                          CMD_CUR_NEXT};

  logic clk;
  logic rst_n;
  int   fail_count, pending_count, words_sent, idle_cycles;
  bit   no_idle, held_off;

  ctrc_in_if  in_chan();
  ctrc_out_if out_chan();

  climate_threshold_relay_controller_unit #(
    .HISTORY_SLOTS(HISTORY_SLOTS),
    .SAVE_PERIOD  (SAVE_PERIOD)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  ctrc_status_checker #(
    .HISTORY_SLOTS(HISTORY_SLOTS),
    .SAVE_PERIOD  (SAVE_PERIOD)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic ctrc_item_t command_word(input logic [7:0] code);
    ctrc_item_t w;
    w.action = 1'b1;
    w.command = code;
    w.temp_int = 8'($urandom);
    w.temp_frac = 8'($urandom);
    w.humi_int = 8'($urandom);
    w.humi_frac = 8'($urandom);
    return w;
  endfunction

  function automatic ctrc_item_t sample_word(input logic [7:0] ti, input logic [7:0] tf,
                                             input logic [7:0] hi, input logic [7:0] hf);
    ctrc_item_t w;
    w.action = 1'b0;
    w.command = 8'($urandom);
    w.temp_int = ti;
    w.temp_frac = tf;
    w.humi_int = hi;
    w.humi_frac = hf;
    return w;
  endfunction

  // Readings cluster around the usable threshold range, with full-range outliers.
  function automatic ctrc_item_t random_sample();
    logic [7:0] ti, tf, hi, hf;
    ti = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 110));
    tf = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
    hi = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 110));
    hf = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
    return sample_word(ti, tf, hi, hf);
  endfunction

  task automatic send_word(input ctrc_item_t w);
    no_idle = (words_sent >= 300 && words_sent < 450);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.action <= w.action;
    in_chan.command <= w.command;
    in_chan.temp_int <= w.temp_int;
    in_chan.temp_frac <= w.temp_frac;
    in_chan.humi_int <= w.humi_int;
    in_chan.humi_frac <= w.humi_frac;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  initial begin
    int goal, kind, len;
    logic [7:0] code;
    rst_n = 1'b0;
    words_sent = 0;
    in_chan.valid <= 1'b0;
    in_chan.action <= 1'b0;
    in_chan.command <= 8'd0;
    in_chan.temp_int <= 8'd0;
    in_chan.temp_frac <= 8'd0;
    in_chan.humi_int <= 8'd0;
    in_chan.humi_frac <= 8'd0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // History view with an empty history: the cursor must stay at zero.
    send_word(command_word(CMD_VIEW));
    send_word(command_word(CMD_CUR_PREV));
    send_word(command_word(CMD_CUR_NEXT));
    send_word(sample_word(8'd0, 8'd0, 8'd0, 8'd0));
    send_word(sample_word(8'd255, 8'd255, 8'd255, 8'd255));
    send_word(sample_word(8'd30, 8'd0, 8'd50, 8'd0));
    send_word(command_word(CMD_BEEP));
    // A nonzero tenths digit lifts the reading just above the upper limit.
    send_word(sample_word(8'd31, 8'd1, 8'd50, 8'd0));
    // Humidity alone out of its window leaves the relays where they are.
    send_word(sample_word(8'd30, 8'd0, 8'd99, 8'd1));
    send_word(command_word(CMD_BEEP));
    send_word(sample_word(8'd29, 8'd0, 8'd0, 8'd0));
    send_word(sample_word(8'd28, 8'd9, 8'd0, 8'd0));
    send_word(command_word(CMD_T_HI_UP));
    send_word(command_word(CMD_T_HI_DOWN));
    send_word(command_word(CMD_H_HI_UP));
    send_word(command_word(CMD_H_HI_DOWN));
    send_word(command_word(CMD_T_LO_UP));
    send_word(command_word(CMD_T_LO_DOWN));
    send_word(command_word(CMD_H_LO_UP));
    send_word(command_word(CMD_H_LO_DOWN));
    send_word(command_word(CMD_HIST_CLEAR));
    send_word(command_word(8'h38));
    send_word(command_word(8'hFF));
    send_word(command_word(8'h00));

    goal = words_sent + RANDOM_WORDS;
    while (words_sent < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        len = $urandom_range(1, 40);
        repeat (len) send_word(random_sample());
      end else if (kind < 80) begin
        // Long runs of one step drive a threshold into saturation or ordering.
        code = STEP_CMDS[3'($urandom_range(0, 7))];
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
        repeat (len) send_word(command_word(code));
      end else if (kind < 94) begin
        len = $urandom_range(1, 10);
        repeat (len) send_word(command_word(NAV_CMDS[2'($urandom_range(0, 3))]));
      end else if (kind < 96) begin
        send_word(command_word(CMD_HIST_CLEAR));
      end else if (kind < 98) begin
        send_word(command_word(CMD_BEEP));
      end else begin
        len = $urandom_range(1, 5);
        repeat (len) begin
          if ($urandom_range(0, 1) == 0) send_word(command_word(8'($urandom)));
          else send_word(random_sample());
        end
      end
    end
    in_chan.valid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("climate_threshold_relay_controller_unit test passed");
    end else begin
      $display("climate_threshold_relay_controller_unit test failed");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off that backs up the pipeline.
  initial begin
    out_chan.ready <= 1'b0;
    held_off = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held_off && words_sent >= 150) begin
        held_off = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      out_chan.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("climate_threshold_relay_controller_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- climate_threshold_relay_controller_unit.f -----
+incdir+design
design/ctrc_pkg.sv
design/ctrc_in_if.sv
design/ctrc_out_if.sv
design/ctrc_in_stage.sv
design/ctrc_core.sv
design/ctrc_out_stage.sv
design/climate_threshold_relay_controller_unit.sv
tb/ctrc_status_checker.sv
tb/tb_top.sv
